// ===== hw/rtl/audio_dsp_accumulator_alu_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the accumulator ALU
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef AUDIO_DSP_ACCUMULATOR_ALU_MACROS_SVH
`define AUDIO_DSP_ACCUMULATOR_ALU_MACROS_SVH
`ifndef SYNTH
`define ADACC_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define ADACC_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ADACC_ASSERT(name, clk, rstn, prop, msg)
`define ADACC_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/adacc_pkg.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU package
// Field widths, instruction codes, decoded operations and request types.
// ----------------------------------------------------------------------------
package adacc_pkg;

  localparam int unsigned ACC_W     = 24;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned ACT_W     = 4;
  localparam int unsigned COEF_FRAC = COEF_W - 2;
  localparam int unsigned ACC_FRAC  = ACC_W - 1;

  // shared multiplier and adder widths
  localparam int unsigned MA_W   = ACC_W + 1;
  localparam int unsigned MB_W   = ACC_W;
  localparam int unsigned PROD_W = MA_W + MB_W;
  localparam int unsigned SH_W   = ACC_W + 4;
  localparam int unsigned SUM_W  = SH_W + 1;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [ACT_W-1:0] ACT_RDAX = 4'd0;
  localparam logic [ACT_W-1:0] ACT_RDFX = 4'd1;
  localparam logic [ACT_W-1:0] ACT_LDAX = 4'd2;
  localparam logic [ACT_W-1:0] ACT_MULX = 4'd3;
  localparam logic [ACT_W-1:0] ACT_MAXX = 4'd4;
  localparam logic [ACT_W-1:0] ACT_WRAX = 4'd5;
  localparam logic [ACT_W-1:0] ACT_WRLX = 4'd6;
  localparam logic [ACT_W-1:0] ACT_WRHX = 4'd7;
  localparam logic [ACT_W-1:0] ACT_SOF  = 4'd8;
  localparam logic [ACT_W-1:0] ACT_ABSA = 4'd9;
  localparam logic [ACT_W-1:0] ACT_AND  = 4'd10;
  localparam logic [ACT_W-1:0] ACT_OR   = 4'd11;
  localparam logic [ACT_W-1:0] ACT_XOR  = 4'd12;
  localparam logic [ACT_W-1:0] ACT_HOST = 4'd13;

  typedef enum logic [3:0] {
    OP_RDAX = 4'd0,
    OP_RDFX = 4'd1,
    OP_LDAX = 4'd2,
    OP_MULX = 4'd3,
    OP_MAXX = 4'd4,
    OP_WRAX = 4'd5,
    OP_WRLX = 4'd6,
    OP_WRHX = 4'd7,
    OP_SOF  = 4'd8,
    OP_ABSA = 4'd9,
    OP_AND  = 4'd10,
    OP_OR   = 4'd11,
    OP_XOR  = 4'd12,
    OP_HOST = 4'd13,
    OP_NOP  = 4'd14
  } op_e;

  typedef struct packed {
    logic [ACT_W-1:0]         action;
    logic [IDX_W-1:0]         reg_index;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [ACC_W-1:0]  offset;
    logic [ACC_W-1:0]         bit_mask;
    logic signed [ACC_W-1:0]  load_value;
  } in_req_t;

  typedef struct packed {
    logic signed [ACC_W-1:0] acc_out;
    logic signed [ACC_W-1:0] reg_value;
    logic                    zero_cross;
    logic                    is_zero;
    logic                    non_negative;
    logic                    is_negative;
  } out_rsp_t;

  // decoded request as it travels through the queue
  typedef struct packed {
    op_e                      op;
    logic [IDX_W-1:0]         idx;
    logic                     idx_ok;
    logic                     reg_wr;
    logic                     acc_wr;
    logic signed [COEF_W-1:0] coef;
    logic [ACC_W-1:0]         operand;
  } uop_t;

endpackage

// ===== hw/rtl/adacc_front.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU front end
// Decodes each request into an operation, index check and single operand.
// ----------------------------------------------------------------------------
module adacc_front #(
  parameter int unsigned REGISTER_COUNT = 64
) (
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  adacc_pkg::in_req_t in_req_i,
  output logic               q_valid_o,
  input  logic               q_ready_i,
  output adacc_pkg::uop_t    q_uop_o
);

  adacc_pkg::uop_t uop;

  always_comb begin
    uop        = '0;
    uop.idx    = in_req_i.reg_index;
    uop.coef   = in_req_i.coefficient;
    uop.idx_ok = 32'(in_req_i.reg_index) < 32'(REGISTER_COUNT);
    uop.acc_wr = in_req_i.action <= adacc_pkg::ACT_XOR;
    uop.reg_wr = uop.idx_ok && (in_req_i.action inside {adacc_pkg::ACT_WRAX,
        adacc_pkg::ACT_WRLX, adacc_pkg::ACT_WRHX, adacc_pkg::ACT_HOST});

    case (in_req_i.action)
      adacc_pkg::ACT_RDAX: uop.op = adacc_pkg::OP_RDAX;
      adacc_pkg::ACT_RDFX: uop.op = adacc_pkg::OP_RDFX;
      adacc_pkg::ACT_LDAX: uop.op = adacc_pkg::OP_LDAX;
      adacc_pkg::ACT_MULX: uop.op = adacc_pkg::OP_MULX;
      adacc_pkg::ACT_MAXX: uop.op = adacc_pkg::OP_MAXX;
      adacc_pkg::ACT_WRAX: uop.op = adacc_pkg::OP_WRAX;
      adacc_pkg::ACT_WRLX: uop.op = adacc_pkg::OP_WRLX;
      adacc_pkg::ACT_WRHX: uop.op = adacc_pkg::OP_WRHX;
      adacc_pkg::ACT_SOF:  uop.op = adacc_pkg::OP_SOF;
      adacc_pkg::ACT_ABSA: uop.op = adacc_pkg::OP_ABSA;
      adacc_pkg::ACT_AND:  uop.op = adacc_pkg::OP_AND;
      adacc_pkg::ACT_OR:   uop.op = adacc_pkg::OP_OR;
      adacc_pkg::ACT_XOR:  uop.op = adacc_pkg::OP_XOR;
      adacc_pkg::ACT_HOST: uop.op = adacc_pkg::OP_HOST;
      default:             uop.op = adacc_pkg::OP_NOP;
    endcase

    // fold the three wide constants into one operand slot
    if (in_req_i.action == adacc_pkg::ACT_SOF) begin
      uop.operand = in_req_i.offset;
    end else if (in_req_i.action inside {adacc_pkg::ACT_AND, adacc_pkg::ACT_OR,
        adacc_pkg::ACT_XOR}) begin
      uop.operand = in_req_i.bit_mask;
    end else if (in_req_i.action == adacc_pkg::ACT_HOST) begin
      uop.operand = in_req_i.load_value;
    end else begin
      uop.operand = '0;
    end
  end

  assign q_valid_o  = in_valid_i;
  assign in_ready_o = q_ready_i;
  assign q_uop_o    = uop;

endmodule

// ===== hw/rtl/adacc_fifo.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU request queue
// Short FIFO of decoded requests between the front and back ends.
// ----------------------------------------------------------------------------
module adacc_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  adacc_pkg::uop_t push_data_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output adacc_pkg::uop_t pop_data_o
);

  localparam int unsigned Depth = adacc_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  adacc_pkg::uop_t   slots_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != CntW'(Depth);
  assign pop_valid_o  = count_q != '0;
  assign pop_data_o   = slots_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hw/rtl/adacc_back.sv =====
// ----------------------------------------------------------------------------
// Accumulator ALU back end
// Register file read stage, combinational execute and output register.
// ----------------------------------------------------------------------------
`include "audio_dsp_accumulator_alu_macros.svh"

module adacc_back #(
  parameter int unsigned REGISTER_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                uop_valid_i,
  output logic                uop_ready_o,
  input  adacc_pkg::uop_t     uop_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output adacc_pkg::out_rsp_t out_rsp_o
);

  localparam int unsigned AccW  = adacc_pkg::ACC_W;
  localparam int unsigned MaW   = adacc_pkg::MA_W;
  localparam int unsigned MbW   = adacc_pkg::MB_W;
  localparam int unsigned ProdW = adacc_pkg::PROD_W;
  localparam int unsigned ShW   = adacc_pkg::SH_W;
  localparam int unsigned SumW  = adacc_pkg::SUM_W;
  localparam int unsigned MemAw = $clog2(REGISTER_COUNT);

  function automatic logic signed [AccW-1:0] sat_acc(input logic signed [SumW-1:0] x);
    logic [SumW-AccW:0] top;
    top = x[SumW-1:AccW-1];
    if (top == '0 || top == '1) begin
      return x[AccW-1:0];
    end else if (x[SumW-1]) begin
      return {1'b1, {(AccW-1){1'b0}}};
    end else begin
      return {1'b0, {(AccW-1){1'b1}}};
    end
  endfunction

  // register file and valid bits
  logic [AccW-1:0]           mem_q [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_q;

  // read stage
  logic                      r_valid_q;
  adacc_pkg::uop_t           r_uop_q;
  logic [AccW-1:0]           rdata_q;
  logic                      rvld_q;
  logic                      byp_q;
  logic [AccW-1:0]           byp_data_q;

  // architectural state and output register
  logic signed [AccW-1:0]    acc_q, acc_d, prev_q, prev_d;
  logic                      out_valid_q;
  adacc_pkg::out_rsp_t       out_rsp_q, rsp_d;

  logic                      ex_fire, r_load, wr_en;
  logic [MemAw-1:0]          waddr, raddr;
  logic [AccW-1:0]           wdata;
  logic signed [AccW-1:0]    r_val, acc_nxt, abs_a, abs_t;
  logic signed [MaW-1:0]     mul_a;
  logic signed [MbW-1:0]     mul_b;
  logic signed [ProdW-1:0]   prod;
  logic signed [ShW-1:0]     prod_sh;
  logic signed [SumW-1:0]    addend, sum, a_ext, t_ext;

  assign ex_fire     = r_valid_q && (!out_valid_q || out_ready_i);
  assign uop_ready_o = !r_valid_q || ex_fire;
  assign r_load      = uop_valid_i && uop_ready_o;

  assign raddr = uop_i.idx[MemAw-1:0];
  assign waddr = r_uop_q.idx[MemAw-1:0];
  assign wr_en = ex_fire && r_uop_q.reg_wr;
  assign wdata = (r_uop_q.op == adacc_pkg::OP_HOST) ? r_uop_q.operand : acc_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[waddr] <= wdata;
    end
    if (r_load) begin
      rdata_q    <= mem_q[raddr];
      byp_data_q <= wdata;
      r_uop_q    <= uop_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      r_valid_q <= 1'b0;
      rvld_q    <= 1'b0;
      byp_q     <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[waddr] <= 1'b1;
      end
      if (r_load) begin
        r_valid_q <= 1'b1;
        rvld_q    <= uop_i.idx_ok && vld_q[raddr];
        byp_q     <= wr_en && (waddr == raddr);
      end else if (ex_fire) begin
        r_valid_q <= 1'b0;
      end
    end
  end

  // register operand: forwarded write, stored value, or zero
  always_comb begin
    if (!r_uop_q.idx_ok) begin
      r_val = '0;
    end else if (byp_q) begin
      r_val = byp_data_q;
    end else if (rvld_q) begin
      r_val = rdata_q;
    end else begin
      r_val = '0;
    end
  end

  always_comb begin
    case (r_uop_q.op)
      adacc_pkg::OP_RDAX, adacc_pkg::OP_MAXX: mul_a = MaW'(r_val);
      adacc_pkg::OP_RDFX: mul_a = MaW'(acc_q) - MaW'(r_val);
      adacc_pkg::OP_WRLX: mul_a = MaW'(prev_q) - MaW'(acc_q);
      default:            mul_a = MaW'(acc_q);
    endcase

    mul_b = (r_uop_q.op == adacc_pkg::OP_MULX) ? MbW'(r_val) : MbW'(r_uop_q.coef);
    prod  = ProdW'(mul_a) * ProdW'(mul_b);

    if (r_uop_q.op == adacc_pkg::OP_MULX) begin
      prod_sh = ShW'(prod >>> adacc_pkg::ACC_FRAC);
    end else begin
      prod_sh = ShW'(prod >>> adacc_pkg::COEF_FRAC);
    end

    case (r_uop_q.op)
      adacc_pkg::OP_RDAX: addend = SumW'(acc_q);
      adacc_pkg::OP_RDFX: addend = SumW'(r_val);
      adacc_pkg::OP_WRLX, adacc_pkg::OP_WRHX: addend = SumW'(prev_q);
      adacc_pkg::OP_SOF:  addend = SumW'(signed'(r_uop_q.operand));
      default:            addend = '0;
    endcase

    sum   = SumW'(prod_sh) + addend;
    a_ext = SumW'(acc_q);
    t_ext = SumW'(prod_sh);
    abs_a = sat_acc(a_ext[SumW-1] ? -a_ext : a_ext);
    abs_t = sat_acc(t_ext[SumW-1] ? -t_ext : t_ext);

    case (r_uop_q.op)
      adacc_pkg::OP_RDAX, adacc_pkg::OP_RDFX, adacc_pkg::OP_MULX, adacc_pkg::OP_WRAX,
      adacc_pkg::OP_WRLX, adacc_pkg::OP_WRHX, adacc_pkg::OP_SOF: acc_nxt = sat_acc(sum);
      adacc_pkg::OP_LDAX: acc_nxt = r_val;
      adacc_pkg::OP_MAXX: acc_nxt = (abs_t > abs_a) ? abs_t : abs_a;
      adacc_pkg::OP_ABSA: acc_nxt = abs_a;
      adacc_pkg::OP_AND:  acc_nxt = acc_q & r_uop_q.operand;
      adacc_pkg::OP_OR:   acc_nxt = acc_q | r_uop_q.operand;
      adacc_pkg::OP_XOR:  acc_nxt = acc_q ^ r_uop_q.operand;
      default:            acc_nxt = acc_q;
    endcase

    acc_d  = r_uop_q.acc_wr ? acc_nxt : acc_q;
    prev_d = r_uop_q.acc_wr ? acc_q : prev_q;

    rsp_d.acc_out      = acc_d;
    rsp_d.reg_value    = r_uop_q.reg_wr ? wdata : r_val;
    rsp_d.zero_cross   = prev_d[AccW-1] ^ acc_d[AccW-1];
    rsp_d.is_zero      = acc_d == '0;
    rsp_d.non_negative = !acc_d[AccW-1];
    rsp_d.is_negative  = acc_d[AccW-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ex_fire) begin
        acc_q       <= acc_d;
        prev_q      <= prev_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      out_rsp_q <= rsp_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  `ADACC_ASSERT(a_prev_follows, clk_i, rst_ni, ex_fire && r_uop_q.acc_wr |=> prev_q == $past(acc_q), "previous accumulator not taken from old accumulator")
  `ADACC_ASSERT(a_acc_hold, clk_i, rst_ni, !(ex_fire && r_uop_q.acc_wr) |=> $stable(acc_q) && $stable(prev_q), "accumulator changed without an instruction")
  `ADACC_ASSERT(a_stall_hold, clk_i, rst_ni, r_valid_q && out_valid_q && !out_ready_i |=> r_valid_q && $stable(acc_q), "read stage lost or executed while output stalled")
  `ADACC_ASSERT(a_out_flags, clk_i, rst_ni, !out_valid_q || (out_rsp_q.is_negative != out_rsp_q.non_negative), "sign flags inconsistent")

endmodule

// ===== hw/rtl/audio_dsp_accumulator_alu.sv =====
// Flow: an accepted request is queued, then loaded into the register-file read stage
// and executed into the output register, which offers its result; a stalled output
// holds the read stage. Throughput: one request per cycle while the output is not
// stalled, set by the accumulator update (one shared multiplier and adder) fed by a
// one-port registered register-file read.
// Reset: asynchronous, active low; clears accumulator, previous accumulator, queue,
// stage valids and the register valid bits, so every register reads zero at once.
// ----------------------------------------------------------------------------
// Audio DSP accumulator ALU
// Front end decodes requests, a short queue decouples it from the back end,
// which reads the register file, executes against the accumulator and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module audio_dsp_accumulator_alu #(
  parameter int unsigned REGISTER_COUNT = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  adacc_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output adacc_pkg::out_rsp_t out_rsp_o
);

  // decoded request into the queue
  logic            fe_valid, fe_ready;
  adacc_pkg::uop_t fe_uop;

  // queue head towards the back end
  logic            q_valid, q_ready;
  adacc_pkg::uop_t q_uop;

  // Front end: classify the request, fold its constants into one operand and
  // check the register index against the file depth.
  adacc_front #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .q_valid_o  (fe_valid),
    .q_ready_i  (fe_ready),
    .q_uop_o    (fe_uop)
  );

  // Queue: hold decoded requests while the back end waits on the output side;
  // ready towards the input comes from its fill count only.
  adacc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fe_valid),
    .push_ready_o (fe_ready),
    .push_data_i  (fe_uop),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_data_o   (q_uop)
  );

  // Back end: read the register file, forward a write to the same entry made
  // on the same edge, advance the accumulator and register the result.
  adacc_back #(
    .REGISTER_COUNT(REGISTER_COUNT)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .uop_valid_i (q_valid),
    .uop_ready_o (q_ready),
    .uop_i       (q_uop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

endmodule
